// File: design/pep_pkg.sv
`default_nettype none
package pep_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int FOV_W          = 15;
    localparam int OFS_W          = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 15;
    localparam int SCREEN_W       = 16;

    localparam logic [FOV_W-1:0] FOV_RESET = 15'd256;
    localparam logic [OFS_W-1:0] HW_RESET  = 12'd320;
    localparam logic [OFS_W-1:0] HH_RESET  = 12'd240;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOV = 2'd0,
        REG_HW  = 2'd1,
        REG_HH  = 2'd2
    } reg_idx_t;

    // per-lane flags carried next to the quotient
    typedef struct packed {
        logic behind;
        logic neg;
    } ep_flags_t;

endpackage
`default_nettype wire

// File: design/pep_front.sv
`default_nettype none
module pep_front
    import pep_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int NB = CB + FOV_W - 1,
    parameter int DW = ((CB > FOV_W) ? CB : FOV_W) + 2
) (
    input  wire logic                 clk,
    input  wire logic                 adv,
    input  wire logic [FIELD_W-1:0]   x,
    input  wire logic [FIELD_W-1:0]   y,
    input  wire logic [FIELD_W-1:0]   z,
    input  wire logic [FOV_W-1:0]     fov,
    output logic      [NB-1:0]        num_x,
    output logic      [NB-1:0]        num_y,
    output logic      [DW-1:0]        den,
    output ep_flags_t                 flags_x,
    output ep_flags_t                 flags_y
);

    logic signed [CB-1:0] xs, ys, zs;
    logic signed [DW-1:0] den_s;
    logic [CB-1:0]        ax, ay;

    logic [CB-1:0]    ax_reg, ay_reg;
    logic [DW-1:0]    den1_reg, den2_reg;
    logic [FOV_W-1:0] fov_reg;
    ep_flags_t        fx1_reg, fy1_reg, fx2_reg, fy2_reg;
    logic [NB-1:0]    px_reg, py_reg;

    always_comb
    begin
        xs    = CB'(x);
        ys    = CB'(y);
        zs    = CB'(z);
        den_s = DW'(zs) + $signed({{(DW-FOV_W){1'b0}}, fov});
        ax    = xs[CB-1] ? (~xs + 1'b1) : xs;
        ay    = ys[CB-1] ? (~ys + 1'b1) : ys;
    end

    // stage 1: depth sum, magnitudes, signs
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg         <= ax;
            ay_reg         <= ay;
            fov_reg        <= fov;
            den1_reg       <= den_s;
            fx1_reg.behind <= den_s[DW-1] || (den_s == '0);
            fx1_reg.neg    <= xs[CB-1];
            fy1_reg.behind <= den_s[DW-1] || (den_s == '0);
            fy1_reg.neg    <= ~ys[CB-1];
        end
    end

    // stage 2: scale products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg   <= NB'(ax_reg * fov_reg);
            py_reg   <= NB'(ay_reg * fov_reg);
            den2_reg <= den1_reg;
            fx2_reg  <= fx1_reg;
            fy2_reg  <= fy1_reg;
        end
    end

    assign num_x   = px_reg;
    assign num_y   = py_reg;
    assign den     = den2_reg;
    assign flags_x = fx2_reg;
    assign flags_y = fy2_reg;

endmodule
`default_nettype wire

// File: design/pep_div.sv
`default_nettype none
module pep_div
    import pep_pkg::*;
#(
    parameter int NB = COORD_BITS_DEF + FOV_W - 1,
    parameter int DW = COORD_BITS_DEF + 2
) (
    input  wire logic            clk,
    input  wire logic            adv,
    input  wire logic [NB-1:0]   num,
    input  wire logic [DW-1:0]   den,
    input  wire ep_flags_t       flags_in,
    output logic      [NB-1:0]   quo,
    output ep_flags_t            flags_out
);

    // one quotient bit per stage, restoring form
    genvar i;
    generate
        for (i = 0; i < NB; i++)
        begin : g_stage
            logic [DW-1:0] rem_in, den_in, trial;
            logic [NB-1:0] n_in;
            ep_flags_t     fl_in;
            logic          take;
            logic [DW-1:0] rem_reg;
            logic [NB-1:0] n_reg;
            logic [DW-1:0] den_reg;
            ep_flags_t     fl_reg;

            if (i == 0)
            begin : g_first
                assign rem_in = '0;
                assign n_in   = num;
                assign den_in = den;
                assign fl_in  = flags_in;
            end
            else
            begin : g_rest
                assign rem_in = g_stage[i-1].rem_reg;
                assign n_in   = g_stage[i-1].n_reg;
                assign den_in = g_stage[i-1].den_reg;
                assign fl_in  = g_stage[i-1].fl_reg;
            end

            assign trial = {rem_in[DW-2:0], n_in[NB-1]};
            assign take  = (trial >= den_in);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg <= take ? (trial - den_in) : trial;
                    n_reg   <= {n_in[NB-2:0], take};
                    den_reg <= den_in;
                    fl_reg  <= fl_in;
                end
            end
        end
    endgenerate

    assign quo       = g_stage[NB-1].n_reg;
    assign flags_out = g_stage[NB-1].fl_reg;

endmodule
`default_nettype wire

// File: design/perspective_edge_projection.sv
`default_nettype none
// Channel   Dir  Beat contents
// s_axis    in   one edge: two 3D endpoints (tdata)
// m_axis    out  projected edge (tdata) and behind-viewer flags (tuser)
// cfg       in   register write: field_of_view, half_width, half_height
//
// One edge enters per cycle unless the output stalls. The pipeline has two front
// stages (depth sum, then scale multiply), one stage per quotient bit in
// each of four divider lanes (COORD_BITS+14 bits), and the output register.
// Reset clears the valid bits and loads the register defaults.
// A stall at the output freezes every stage together; nothing drops or repeats.
module perspective_edge_projection
    import pep_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (lowest first)
    input  wire logic [6*FIELD_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // start_screen_x, start_screen_y, end_screen_x, end_screen_y
    output logic [4*SCREEN_W-1:0]      m_tdata,
    // start_behind, end_behind
    output logic [1:0]                 m_tuser,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NB  = COORD_BITS + FOV_W - 1;
    localparam int DW  = ((COORD_BITS > FOV_W) ? COORD_BITS : FOV_W) + 2;
    localparam int LAT = NB + 2;
    localparam int SW  = NB + 2;

    logic [FOV_W-1:0] fov_reg;
    logic [OFS_W-1:0] hw_reg, hh_reg;

    // configuration writes; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fov_reg <= FOV_RESET;
            hw_reg  <= HW_RESET;
            hh_reg  <= HH_RESET;
        end
        else if (cfg_wen)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FOV: fov_reg <= cfg_data[FOV_W-1:0];
                REG_HW:  hw_reg  <= cfg_data[OFS_W-1:0];
                REG_HH:  hh_reg  <= cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances together when the output slot is free or drains
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], s_tvalid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    // lane order: start x, start y, end x, end y
    logic [NB-1:0] num   [4];
    logic [NB-1:0] quo   [4];
    logic [DW-1:0] den   [2];
    ep_flags_t     fl_in [4];
    ep_flags_t     fl_out[4];

    genvar e, k;
    generate
        for (e = 0; e < 2; e++)
        begin : g_ep
            pep_front #(.CB(COORD_BITS), .NB(NB), .DW(DW)) u_front (
                .clk     (clk),
                .adv     (adv),
                .x       (s_tdata[(3*e)*FIELD_W +: FIELD_W]),
                .y       (s_tdata[(3*e+1)*FIELD_W +: FIELD_W]),
                .z       (s_tdata[(3*e+2)*FIELD_W +: FIELD_W]),
                .fov     (fov_reg),
                .num_x   (num[2*e]),
                .num_y   (num[2*e+1]),
                .den     (den[e]),
                .flags_x (fl_in[2*e]),
                .flags_y (fl_in[2*e+1])
            );
            for (k = 0; k < 2; k++)
            begin : g_lane
                pep_div #(.NB(NB), .DW(DW)) u_div (
                    .clk       (clk),
                    .adv       (adv),
                    .num       (num[2*e+k]),
                    .den       (den[e]),
                    .flags_in  (fl_in[2*e+k]),
                    .quo       (quo[2*e+k]),
                    .flags_out (fl_out[2*e+k])
                );
            end
        end
    endgenerate

    // apply sign, add screen center, saturate, force zero when behind
    logic signed [SW-1:0]       sum  [4];
    logic        [SCREEN_W-1:0] scr  [4];
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            sum[l] = fl_out[l].neg ? -$signed({2'b00, quo[l]}) : $signed({2'b00, quo[l]});
            sum[l] = sum[l] + $signed({{(SW-OFS_W){1'b0}}, ((l % 2) == 0) ? hw_reg : hh_reg});
            if (fl_out[l].behind)
                scr[l] = '0;
            else if (sum[l] > $signed(SW'(32767)))
                scr[l] = 16'h7fff;
            else if (sum[l] < -$signed(SW'(32768)))
                scr[l] = 16'h8000;
            else
                scr[l] = sum[l][SCREEN_W-1:0];
        end
    end

    logic [4*SCREEN_W-1:0] data_reg;
    logic [1:0]            user_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= {scr[3], scr[2], scr[1], scr[0]};
            user_reg <= {fl_out[2].behind, fl_out[0].behind};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule
`default_nettype wire

// File: tb/tb_perspective_edge_projection.sv
`default_nettype none
module tb_perspective_edge_projection;
    import pep_pkg::*;

    // Index past the last register: the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // Pipeline depth of the block; drain() adds a margin on top.
    localparam int PIPE_DEPTH  = COORD_BITS_DEF + 17;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [FIELD_W-1:0] sx, sy, sz, ex, ey, ez;
    } edge_t;

    typedef struct {
        logic signed [SCREEN_W-1:0] ssx, ssy, esx, esy;
        logic                       sbh, ebh;
    } screen_edge_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // start_x, start_y, start_z, end_x, end_y, end_z (lowest first)
    logic [6*FIELD_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // start_screen_x, start_screen_y, end_screen_x, end_screen_y (lowest first)
    logic [4*SCREEN_W-1:0] m_tdata;
    // start_behind, end_behind (lowest first)
    logic [1:0]            m_tuser;
    logic                  cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    perspective_edge_projection DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the projection registers.
    logic [FOV_W-1:0] fov_sh = FOV_RESET;
    logic [OFS_W-1:0] hw_sh  = HW_RESET;
    logic [OFS_W-1:0] hh_sh  = HH_RESET;

    edge_t        edge_q[$];      // edges waiting to be offered
    screen_edge_t screen_q[$];    // projections still owed by the block
    int           err_cnt = 0;
    bit           tx_idle_en = 1'b1;
    bit           rx_idle_en = 1'b1;
    bit           hold_req = 1'b0;
    int           hold_cnt = 0;

    function automatic logic signed [SCREEN_W-1:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return SCREEN_W'(v);
    endfunction

    // Project one endpoint; depth at or behind the eye plane yields zeros.
    function automatic void project_point(input logic signed [FIELD_W-1:0] x, y, z,
                                          output logic signed [SCREEN_W-1:0] px, py,
                                          output logic behind);
        longint f, den;
        f = longint'(fov_sh);
        den = longint'(z) + f;
        if (den <= 0) begin
            px = '0;
            py = '0;
            behind = 1'b1;
        end else begin
            px = clamp16((longint'(x) * f) / den + longint'(hw_sh));
            py = clamp16((-longint'(y) * f) / den + longint'(hh_sh));
            behind = 1'b0;
        end
    endfunction

    function automatic screen_edge_t project_edge(edge_t e);
        screen_edge_t r;
        project_point(e.sx, e.sy, e.sz, r.ssx, r.ssy, r.sbh);
        project_point(e.ex, e.ey, e.ez, r.esx, r.esy, r.ebh);
        return r;
    endfunction

    // Driver: record the accepted beat, then offer the next edge or idle.
    always @(posedge clk) begin
        edge_t nxt;
        if (s_tvalid && s_tready)
            screen_q.push_back(project_edge(edge_q.pop_front()));
        if (rst_n && !(s_tvalid && !s_tready)) begin
            if (edge_q.size() > (s_tvalid && s_tready ? 0 : 0) &&
                !(tx_idle_en && $urandom_range(99) < 32)) begin
                nxt = edge_q[0];
                s_tvalid <= 1'b1;
                s_tdata <= {nxt.ez, nxt.ey, nxt.ex, nxt.sz, nxt.sy, nxt.sx};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random backpressure, or a long hold-off on request.
    always @(posedge clk) begin
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            m_tready <= 1'b0;
        end else begin
            if (!hold_req) hold_cnt <= 0;
            m_tready <= !(rx_idle_en && $urandom_range(99) < 32);
        end
    end

    // Monitor: compare every accepted result beat with the oldest projection.
    always @(posedge clk) begin
        screen_edge_t exp_r;
        if (m_tvalid && m_tready) begin
            if (screen_q.size() == 0) begin
                $error("unexpected result beat %h/%b", m_tdata, m_tuser);
                err_cnt++;
            end else begin
                exp_r = screen_q.pop_front();
                if (m_tdata[15:0] !== exp_r.ssx) begin
                    $error("start_screen_x exp %0d got %0d", exp_r.ssx,
                           $signed(m_tdata[15:0]));
                    err_cnt++;
                end
                if (m_tdata[31:16] !== exp_r.ssy) begin
                    $error("start_screen_y exp %0d got %0d", exp_r.ssy,
                           $signed(m_tdata[31:16]));
                    err_cnt++;
                end
                if (m_tdata[47:32] !== exp_r.esx) begin
                    $error("end_screen_x exp %0d got %0d", exp_r.esx,
                           $signed(m_tdata[47:32]));
                    err_cnt++;
                end
                if (m_tdata[63:48] !== exp_r.esy) begin
                    $error("end_screen_y exp %0d got %0d", exp_r.esy,
                           $signed(m_tdata[63:48]));
                    err_cnt++;
                end
                if (m_tuser[0] !== exp_r.sbh) begin
                    $error("start_behind exp %0b got %0b", exp_r.sbh, m_tuser[0]);
                    err_cnt++;
                end
                if (m_tuser[1] !== exp_r.ebh) begin
                    $error("end_behind exp %0b got %0b", exp_r.ebh, m_tuser[1]);
                    err_cnt++;
                end
            end
        end
    end

    // Coordinate mix: full range, small values, extremes, and depths near the eye plane.
    function automatic logic signed [FIELD_W-1:0] rand_coord(bit is_depth);
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return FIELD_W'($urandom);
        if (sel < 7) return FIELD_W'($urandom_range(2000) - 1000);
        if (is_depth) return FIELD_W'(-int'(fov_sh) + $urandom_range(6) - 3);
        return sel == 7 ? 16'sh7fff : 16'sh8000;
    endfunction

    task automatic queue_random(int n);
        edge_t e;
        repeat (n) begin
            e.sx = rand_coord(0);
            e.sy = rand_coord(0);
            e.sz = rand_coord(1);
            e.ex = rand_coord(0);
            e.ey = rand_coord(0);
            e.ez = rand_coord(1);
            edge_q.push_back(e);
        end
    endtask

    task automatic queue_edge(int a, b, c, d, f, g);
        edge_t e;
        e.sx = FIELD_W'(a); e.sy = FIELD_W'(b); e.sz = FIELD_W'(c);
        e.ex = FIELD_W'(d); e.ey = FIELD_W'(f); e.ez = FIELD_W'(g);
        edge_q.push_back(e);
    endtask

    // Hold the sender until every owed projection is back, then let the
    // pipeline empty before touching the registers.
    task automatic drain();
        @(negedge clk);
        while (edge_q.size() != 0 || s_tvalid || screen_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        case (idx)
            REG_FOV: fov_sh = FOV_W'(val);
            REG_HW:  hw_sh  = OFS_W'(val);
            REG_HH:  hh_sh  = OFS_W'(val);
            default: ;
        endcase
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic set_view(int f, int w, int h);
        write_reg(REG_FOV, f);
        write_reg(REG_HW, w);
        write_reg(REG_HH, h);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset view first: extremes, eye-plane depth, overflow just ahead of it.
        queue_edge(0, 0, 0, 0, 0, 0);
        queue_edge(32767, 32767, 32767, -32768, -32768, -32768);
        queue_edge(-32768, -32768, 32767, 32767, 32767, -32768);
        queue_edge(100, 100, -256, 100, 100, -255);
        queue_edge(32767, -32768, -255, -32768, 32767, -255);
        queue_edge(-1, 1, -257, 5, -5, -300);
        queue_edge(7, -7, 1, -7, 7, -1);
        queue_edge(-32768, 32767, 0, 32767, -32768, 0);
        queue_random(350);
        drain();

        // Large view with a long output hold-off so the pipeline backs up.
        set_view(32767, 4095, 4095);
        write_reg(REG_SPARE, 12345);
        queue_edge(32767, -32768, -32766, -32768, 32767, -32767);
        queue_edge(1, 1, -32767, -1, -1, 32767);
        queue_random(200);
        hold_req = 1'b1;
        drain();
        hold_req = 1'b0;

        // Narrowest view, origin offsets, no idling on either side.
        set_view(1, 0, 0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        queue_edge(32767, -32768, 0, -32768, 32767, -1);
        queue_random(250);
        drain();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // Zero scale: visible points land on the screen center.
        set_view(0, 1234, 2345);
        queue_edge(500, -500, 1, 500, -500, 0);
        queue_random(150);
        drain();

        // Random views.
        repeat (4) begin
            set_view($urandom_range(32767, 1), $urandom_range(4095), $urandom_range(4095));
            queue_random(110);
            drain();
        end

        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
design/pep_pkg.sv
design/pep_front.sv
design/pep_div.sv
design/perspective_edge_projection.sv
tb/tb_perspective_edge_projection.sv
